/* src/sli_pkg.sv */
// Package for the sorted list store: field widths, operation and status codes,
// and the command bundle passed from the controller to the datapath.
// No dependencies.
package sli_pkg;

  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;
  localparam int CAPACITY_DEFAULT = 16;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic load;
    logic update;
  } cmd_t;

endpackage

/* src/sli_ctrl.sv */
// Controller for the sorted list store: sequences the capture and update steps
// and runs the request and response handshakes.
// Depends on sli_pkg.
module sli_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output sli_pkg::cmd_t cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  always_comb begin
    cmd.load = 1'b0;
    cmd.update = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.update) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_load_then_update: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_UPDATE)
    else $error("captured request did not move to the update step");

  a_update_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> rsp_valid)
    else $error("update did not present a response");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.update))
    else $error("capture and update issued together");

  a_blocked_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE && rsp_valid && rsp_stall |=> state == S_UPDATE)
    else $error("update overwrote a response that was not taken");

endmodule

/* src/sli_datapath.sv */
// Datapath for the sorted list store: a row of entry cells with per-cell
// compare flags, the entry count and the response register.
// Depends on sli_pkg.
module sli_datapath #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sli_pkg::cmd_t                       cmd,
  input  logic                                func,
  input  logic signed [sli_pkg::DATA_W-1:0]   value,
  output logic [sli_pkg::STATUS_W-1:0]        status,
  output logic [sli_pkg::COUNT_W-1:0]         count,
  output logic                                is_empty,
  output logic signed [sli_pkg::DATA_W-1:0]   smallest
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [sli_pkg::DATA_W-1:0] entries [CAPACITY];
  logic signed [sli_pkg::DATA_W-1:0] entries_next [CAPACITY];
  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;

  logic func_q;
  logic signed [sli_pkg::DATA_W-1:0] value_q;
  logic [CAPACITY-1:0] le_q;
  logic [CAPACITY-1:0] ge_q;
  logic [CAPACITY-1:0] eq_q;
  logic [CAPACITY-1:0] le_d;
  logic [CAPACITY-1:0] ge_d;
  logic [CAPACITY-1:0] eq_d;
  logic [CAPACITY-1:0] first_eq;

  logic full;
  logic found;
  logic do_ins;
  logic do_rem;
  logic [sli_pkg::STATUS_W-1:0] status_next;
  logic [CW+sli_pkg::COUNT_W-1:0] count_ext;

  logic [sli_pkg::STATUS_W-1:0] status_q;
  logic [sli_pkg::COUNT_W-1:0] count_q;
  logic empty_q;
  logic signed [sli_pkg::DATA_W-1:0] smallest_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic vld;
    logic signed [sli_pkg::DATA_W-1:0] ins_val;
    logic signed [sli_pkg::DATA_W-1:0] rem_val;

    assign vld = CW'(g) < entry_count;
    assign le_d[g] = vld && (entries[g] <= value);
    assign ge_d[g] = vld && (entries[g] >= value);
    assign eq_d[g] = vld && (entries[g] == value);

    if (g == 0) begin : g_head
      assign ins_val = le_q[g] ? entries[g] : value_q;
      assign first_eq[g] = eq_q[g];
    end else begin : g_body
      assign ins_val = le_q[g] ? entries[g] : (le_q[g-1] ? value_q : entries[g-1]);
      assign first_eq[g] = eq_q[g] && !eq_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rem_val = entries[g];
    end else begin : g_inner
      assign rem_val = ge_q[g] ? entries[g+1] : entries[g];
    end

    assign entries_next[g] = do_ins ? ins_val : (do_rem ? rem_val : entries[g]);
  end

  assign full = (entry_count == CW'(CAPACITY));
  assign found = |first_eq;
  assign do_ins = cmd.update && (func_q == sli_pkg::FN_INSERT) && !full;
  assign do_rem = cmd.update && (func_q == sli_pkg::FN_REMOVE) && found;

  always_comb begin
    entry_count_next = entry_count;
    if (do_ins) begin
      entry_count_next = entry_count + CW'(1);
    end else if (do_rem) begin
      entry_count_next = entry_count - CW'(1);
    end
  end

  always_comb begin
    status_next = sli_pkg::ST_DONE;
    if (func_q == sli_pkg::FN_INSERT) begin
      if (full) begin
        status_next = sli_pkg::ST_FULL;
      end
    end else if (!found) begin
      status_next = sli_pkg::ST_NOT_FOUND;
    end
  end

  assign count_ext = {{sli_pkg::COUNT_W{1'b0}}, entry_count_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      value_q <= value;
      le_q <= le_d;
      ge_q <= ge_d;
      eq_q <= eq_d;
    end
    if (cmd.update) begin
      entries <= entries_next;
      status_q <= status_next;
      count_q <= count_ext[sli_pkg::COUNT_W-1:0];
      empty_q <= (entry_count_next == '0);
      smallest_q <= (entry_count_next == '0) ? '0 : entries_next[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  assign status = status_q;
  assign count = count_q;
  assign is_empty = empty_q;
  assign smallest = smallest_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

endmodule

/* src/sorted_list_insert_remove_top.sv */
// Top level of the sorted list store: joins the controller and the datapath.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
//
//   Channel   Direction  Handshake              Payload
//   request   in         req_valid / req_stall  func, value
//   response  out        rsp_valid / rsp_stall  status, count, is_empty, smallest
//
// Each request first compares the value against every cell in parallel and captures
// the flags, then in the update step shifts the cell row and loads the response.
// The update step waits while an earlier response is still stalled.
// Reset clears the entry count; the cells themselves are not cleared.
// A new request is taken as soon as the previous one has been applied.
module sorted_list_insert_remove_top #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                func,
  input  logic signed [sli_pkg::DATA_W-1:0]   value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [sli_pkg::STATUS_W-1:0]        status,
  output logic [sli_pkg::COUNT_W-1:0]         count,
  output logic                                is_empty,
  output logic signed [sli_pkg::DATA_W-1:0]   smallest
);

  sli_pkg::cmd_t cmd;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  sli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .func     (func),
    .value    (value),
    .status   (status),
    .count    (count),
    .is_empty (is_empty),
    .smallest (smallest)
  );

endmodule
